/* rtl/core/sswm_pkg.sv */
// shared types and constants for the streaming string wait matcher
`default_nettype none
package sswm_pkg;

  localparam int MAX_PATTERN_BYTES = 8;
  localparam int PAT_W  = 64;
  localparam int LEN_W  = 4;
  localparam int PROG_W = 4;
  localparam int STS_W  = 2;
  localparam int CNT_W  = $clog2(MAX_PATTERN_BYTES + 1);
  localparam int IDX_W  = (MAX_PATTERN_BYTES > 1) ? $clog2(MAX_PATTERN_BYTES) : 1;
  localparam int ADDR_W = 4;
  localparam int DATA_W = 64;

  typedef enum logic [0:0] {
    CMD_BYTE    = 1'b0,
    CMD_TIMEOUT = 1'b1
  } cmd_t;

  typedef enum logic [STS_W-1:0] {
    STS_WAITING = 2'd0,
    STS_FOUND   = 2'd1,
    STS_TIMEOUT = 2'd2
  } sts_t;

  typedef enum logic [0:0] {
    REG_PATTERN = 1'b0,
    REG_LENGTH  = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic load;
    logic commit;
  } ctl_cmd_t;

endpackage
`default_nettype wire

/* rtl/core/sswm_if.sv */
// valid/ready stream interfaces for the input and result words
`default_nettype none
interface sswm_in_if;
  logic       valid;
  logic       ready;
  logic       cmd;
  logic [7:0] rx_byte;
  modport source (output valid, output cmd, output rx_byte, input ready);
  modport sink   (input valid, input cmd, input rx_byte, output ready);
endinterface

interface sswm_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic [3:0] progress;
  modport source (output valid, output status, output progress, input ready);
  modport sink   (input valid, input status, input progress, output ready);
endinterface
`default_nettype wire

/* rtl/core/sswm_ctrl.sv */
// controller: sequences load, evaluate and result handoff
`default_nettype none
module sswm_ctrl
  import sswm_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  wire logic     out_ready,
  output ctl_cmd_t      cmd
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_CALC = 2'b10
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt  = state_r;
    cmd.load   = 1'b0;
    cmd.commit = 1'b0;
    in_ready   = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_CALC;
        end
      end
      ST_CALC: begin
        // result register free or being drained this cycle
        if (!out_valid_r || out_ready) begin
          cmd.commit = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.commit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule
`default_nettype wire

/* rtl/core/sswm_dp.sv */
// datapath: pattern registers, comparator cells and match count
`default_nettype none
module sswm_dp
  import sswm_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire ctl_cmd_t          cmd,
  input  wire logic              in_cmd,
  input  wire logic [7:0]        in_byte,
  input  wire logic              cfg_we,
  input  wire reg_idx_t          cfg_sel,
  input  wire logic [DATA_W-1:0] cfg_wdata,
  output logic [PAT_W-1:0]       pattern,
  output logic [LEN_W-1:0]       length,
  output logic [STS_W-1:0]       status,
  output logic [PROG_W-1:0]      progress
);

  logic [PAT_W-1:0]  pattern_r;
  logic [LEN_W-1:0]  length_r;
  logic [CNT_W-1:0]  cnt_r;
  logic              in_cmd_r;
  logic [7:0]        in_byte_r;
  logic [STS_W-1:0]  status_r;
  logic [PROG_W-1:0] progress_r;

  logic [7:0]        pb [MAX_PATTERN_BYTES];
  logic [LEN_W-1:0]  len_eff;
  logic [CNT_W-1:0]  lim;
  logic [CNT_W-1:0]  c;
  logic [CNT_W-1:0]  c_inc;
  logic              hit;
  logic [MAX_PATTERN_BYTES-1:0] cand;
  logic [CNT_W-1:0]  best;
  logic [CNT_W-1:0]  idx;
  logic [CNT_W-1:0]  cnt_nxt;
  sts_t              sts_nxt;

  always_comb begin
    for (int j = 0; j < MAX_PATTERN_BYTES; j++) begin
      pb[j] = pattern_r[8*j +: 8];
    end

    if (length_r == '0) begin
      len_eff = LEN_W'(1);
    end else if (length_r > LEN_W'(MAX_PATTERN_BYTES)) begin
      len_eff = LEN_W'(MAX_PATTERN_BYTES);
    end else begin
      len_eff = length_r;
    end
    lim   = CNT_W'(len_eff - LEN_W'(1));
    c     = (cnt_r > lim) ? lim : cnt_r;
    c_inc = c + CNT_W'(1);
    hit   = (pb[c[IDX_W-1:0]] == in_byte_r);

    // one cell per candidate suffix length k
    cand = '0;
    idx  = '0;
    for (int k = 1; k < MAX_PATTERN_BYTES; k++) begin
      cand[k] = (CNT_W'(k) <= c) && (in_byte_r == pb[k-1]);
      for (int i = 0; i < MAX_PATTERN_BYTES - 1; i++) begin
        if (i < k - 1) begin
          idx = c_inc - CNT_W'(k) + CNT_W'(i);
          if (pb[idx[IDX_W-1:0]] != pb[i]) begin
            cand[k] = 1'b0;
          end
        end
      end
    end

    // longest surviving suffix
    best = '0;
    for (int k = 1; k < MAX_PATTERN_BYTES; k++) begin
      if (cand[k]) begin
        best = CNT_W'(k);
      end
    end

    if (in_cmd_r == CMD_TIMEOUT) begin
      sts_nxt = STS_TIMEOUT;
      cnt_nxt = '0;
    end else if (hit) begin
      if (LEN_W'(c_inc) == len_eff) begin
        sts_nxt = STS_FOUND;
        cnt_nxt = '0;
      end else begin
        sts_nxt = STS_WAITING;
        cnt_nxt = c_inc;
      end
    end else begin
      sts_nxt = STS_WAITING;
      cnt_nxt = best;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pattern_r <= '0;
      length_r  <= LEN_W'(1);
      cnt_r     <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_sel)
          REG_PATTERN: pattern_r <= cfg_wdata[PAT_W-1:0];
          REG_LENGTH:  length_r  <= cfg_wdata[LEN_W-1:0];
          default: ;
        endcase
      end
      if (cmd.commit) begin
        cnt_r <= cnt_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      in_cmd_r  <= in_cmd;
      in_byte_r <= in_byte;
    end
    if (cmd.commit) begin
      status_r   <= sts_nxt;
      progress_r <= PROG_W'(cnt_nxt);
    end
  end

  assign pattern  = pattern_r;
  assign length   = length_r;
  assign status   = status_r;
  assign progress = progress_r;

endmodule
`default_nettype wire

/* rtl/core/stream_string_wait_matcher_core.sv */
// top level of the streaming string wait matcher
// a taken word is registered; its result is registered onto out_ch when committed
// the controller's load/evaluate sequence takes no new word while one is evaluated
// a new word is taken while the previous result still waits on out_ch
// reset (rst_n low, synchronous): match count 0, pattern 0, length 1, no result pending
// all suffix candidates are compared in parallel cells in the evaluate cycle
`default_nettype none
module stream_string_wait_matcher_core
  import sswm_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  sswm_in_if.sink                in_ch,
  sswm_out_if.source             out_ch,
  input  wire logic              cfg_psel,
  input  wire logic              cfg_penable,
  input  wire logic              cfg_pwrite,
  input  wire logic [ADDR_W-1:0] cfg_paddr,
  input  wire logic [DATA_W-1:0] cfg_pwdata,
  output logic [DATA_W-1:0]      cfg_prdata,
  output logic                   cfg_pready
);

  ctl_cmd_t          cmd;
  logic              cfg_we;
  reg_idx_t          cfg_sel;
  logic [PAT_W-1:0]  pattern;
  logic [LEN_W-1:0]  length;

  // apb: no wait states, register select by 8-byte slot
  assign cfg_pready = 1'b1;
  assign cfg_we     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_sel    = reg_idx_t'(cfg_paddr[3]);

  // read back mux
  always_comb begin
    case (cfg_sel)
      REG_PATTERN: cfg_prdata = DATA_W'(pattern);
      REG_LENGTH:  cfg_prdata = DATA_W'(length);
      default:     cfg_prdata = '0;
    endcase
  end

  // controller owns the handshakes and the result-valid flag
  sswm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd)
  );

  // datapath holds the word, the pattern and the running match count
  sswm_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_cmd    (in_ch.cmd),
    .in_byte   (in_ch.rx_byte),
    .cfg_we    (cfg_we),
    .cfg_sel   (cfg_sel),
    .cfg_wdata (cfg_pwdata),
    .pattern   (pattern),
    .length    (length),
    .status    (out_ch.status),
    .progress  (out_ch.progress)
  );

endmodule
`default_nettype wire

/* rtl/core/sswm_checker.sv */
// port-level assertions for the matcher and their bind
`default_nettype none
module sswm_checker
  import sswm_pkg::*;
(
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              out_valid,
  input wire logic              out_ready,
  input wire logic [STS_W-1:0]  status,
  input wire logic [PROG_W-1:0] progress
);

  // stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(progress))
    else $error("result word changed while stalled");

  // completion always restarts the count
  a_done_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (status == STS_FOUND || status == STS_TIMEOUT) |-> progress == '0)
    else $error("nonzero progress on completion");

  // no undefined status code
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (status == STS_WAITING || status == STS_FOUND || status == STS_TIMEOUT))
    else $error("bad status code");

  // a full match never shows as progress
  a_prog_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> progress < PROG_W'(MAX_PATTERN_BYTES))
    else $error("progress out of range");

endmodule

bind stream_string_wait_matcher_core sswm_checker u_sswm_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .status    (out_ch.status),
  .progress  (out_ch.progress)
);
`default_nettype wire

/* dv/stream_string_wait_matcher_core_tb.sv */
// self-checking testbench for the streaming string wait matcher core
module stream_string_wait_matcher_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import sswm_pkg::*;

  localparam int CLK_PERIOD      = 10;
  localparam int RESET_CYCLES    = 7;
  // slowest legal run: a receiver stalling 85 percent of the time keeps a word waiting,
  // and the long hold-off is HOLD_CYCLES; both stay well below this
  localparam int WATCHDOG_LIMIT  = 4000;
  localparam int HOLD_CYCLES     = 300;
  // margin after the last expected result is taken, before registers are touched
  localparam int SETTLE_CYCLES   = 6;
  localparam int NUM_PHASES      = 6;
  localparam int ITEMS_PER_PHASE = 125;
  localparam int PRINT_CAP       = 50;
  localparam int NUM_ROWS        = 32;

  // one result word as the block reports it
  typedef struct packed {
    sts_t                status;
    logic [PROG_W-1:0]   progress;
  } match_result_t;

  typedef enum logic [0:0] {
    ROW_WORD = 1'b0,
    ROW_REG  = 1'b1
  } row_kind_t;

  // one line of the directed script: either an input word or a register write
  typedef struct packed {
    row_kind_t           kind;
    cmd_t                cmd;
    reg_idx_t            regsel;
    logic [PAT_W-1:0]    value;
    logic                typed;
    match_result_t       result;
  } script_row_t;

  // pattern "ABABAC" then 0x00 and 0xff, first byte lowest
  localparam logic [PAT_W-1:0] OVERLAP_PATTERN = 64'hFF00_4341_4241_4241;

  // directed script: typed results only where they are obvious, the rest go
  // through the predictor
  localparam script_row_t DIRECTED [NUM_ROWS] = '{
    // after reset: pattern all zero, length 1
    '{ROW_WORD, CMD_BYTE,    REG_PATTERN, 64'h00, 1'b1, '{STS_FOUND,   4'd0}},
    '{ROW_WORD, CMD_TIMEOUT, REG_PATTERN, 64'hFF, 1'b1, '{STS_TIMEOUT, 4'd0}},
    '{ROW_WORD, CMD_BYTE,    REG_PATTERN, 64'hFF, 1'b1, '{STS_WAITING, 4'd0}},
    // full-length pattern with a self-overlapping head
    '{ROW_REG,  CMD_BYTE,    REG_PATTERN, OVERLAP_PATTERN, 1'b0, '{STS_WAITING, 4'd0}},
    '{ROW_REG,  CMD_BYTE,    REG_LENGTH,  64'd8,  1'b0, '{STS_WAITING, 4'd0}},
    '{ROW_WORD, CMD_BYTE,    REG_PATTERN, 64'h41, 1'b0, '{STS_WAITING, 4'd0}},
    '{ROW_WORD, CMD_BYTE,    REG_PATTERN, 64'h42, 1'b0, '{STS_WAITING, 4'd0}},
    '{ROW_WORD, CMD_BYTE,    REG_PATTERN, 64'h41, 1'b0, '{STS_WAITING, 4'd0}},
    '{ROW_WORD, CMD_BYTE,    REG_PATTERN, 64'h42, 1'b0, '{STS_WAITING, 4'd0}},
    '{ROW_WORD, CMD_BYTE,    REG_PATTERN, 64'h41, 1'b0, '{STS_WAITING, 4'd0}},
    // breaks the match at the sixth byte, window slides back to "ABAB"
    '{ROW_WORD, CMD_BYTE,    REG_PATTERN, 64'h42, 1'b0, '{STS_WAITING, 4'd0}},
    '{ROW_WORD, CMD_BYTE,    REG_PATTERN, 64'h41, 1'b0, '{STS_WAITING, 4'd0}},
    '{ROW_WORD, CMD_BYTE,    REG_PATTERN, 64'h43, 1'b0, '{STS_WAITING, 4'd0}},
    '{ROW_WORD, CMD_BYTE,    REG_PATTERN, 64'h00, 1'b0, '{STS_WAITING, 4'd0}},
    '{ROW_WORD, CMD_BYTE,    REG_PATTERN, 64'hFF, 1'b0, '{STS_WAITING, 4'd0}},
    // timeout in the middle of a partial match
    '{ROW_WORD, CMD_BYTE,    REG_PATTERN, 64'h41, 1'b0, '{STS_WAITING, 4'd0}},
    '{ROW_WORD, CMD_BYTE,    REG_PATTERN, 64'h42, 1'b0, '{STS_WAITING, 4'd0}},
    '{ROW_WORD, CMD_TIMEOUT, REG_PATTERN, 64'h00, 1'b1, '{STS_TIMEOUT, 4'd0}},
    // length zero behaves as one
    '{ROW_REG,  CMD_BYTE,    REG_LENGTH,  64'd0,  1'b0, '{STS_WAITING, 4'd0}},
    '{ROW_WORD, CMD_BYTE,    REG_PATTERN, 64'h41, 1'b1, '{STS_FOUND,   4'd0}},
    '{ROW_WORD, CMD_BYTE,    REG_PATTERN, 64'h00, 1'b1, '{STS_WAITING, 4'd0}},
    // length above the maximum saturates
    '{ROW_REG,  CMD_BYTE,    REG_LENGTH,  64'd15, 1'b0, '{STS_WAITING, 4'd0}},
    '{ROW_WORD, CMD_BYTE,    REG_PATTERN, 64'h41, 1'b0, '{STS_WAITING, 4'd0}},
    '{ROW_WORD, CMD_BYTE,    REG_PATTERN, 64'h42, 1'b0, '{STS_WAITING, 4'd0}},
    // length cut below the current count: count capped, then completes
    '{ROW_REG,  CMD_BYTE,    REG_LENGTH,  64'd2,  1'b0, '{STS_WAITING, 4'd0}},
    '{ROW_WORD, CMD_BYTE,    REG_PATTERN, 64'h42, 1'b1, '{STS_FOUND,   4'd0}},
    // pattern swapped mid-search: prefix is taken from the new pattern
    '{ROW_REG,  CMD_BYTE,    REG_LENGTH,  64'd8,  1'b0, '{STS_WAITING, 4'd0}},
    '{ROW_WORD, CMD_BYTE,    REG_PATTERN, 64'h41, 1'b0, '{STS_WAITING, 4'd0}},
    '{ROW_WORD, CMD_BYTE,    REG_PATTERN, 64'h42, 1'b0, '{STS_WAITING, 4'd0}},
    '{ROW_WORD, CMD_BYTE,    REG_PATTERN, 64'h41, 1'b0, '{STS_WAITING, 4'd0}},
    '{ROW_REG,  CMD_BYTE,    REG_PATTERN, {PAT_W{1'b1}}, 1'b0, '{STS_WAITING, 4'd0}},
    '{ROW_WORD, CMD_BYTE,    REG_PATTERN, 64'hFF, 1'b0, '{STS_WAITING, 4'd0}}
  };

  logic                clk = 1'b0;
  logic                rst_n;
  logic                cfg_psel;
  logic                cfg_penable;
  logic                cfg_pwrite;
  logic [ADDR_W-1:0]   cfg_paddr;
  logic [DATA_W-1:0]   cfg_pwdata;
  logic [DATA_W-1:0]   cfg_prdata;
  logic                cfg_pready;

  sswm_in_if  in_ch ();
  sswm_out_if out_ch ();

  // shadow of the registers and the match count
  logic [PAT_W-1:0]    pattern_shadow = '0;
  logic [LEN_W-1:0]    length_shadow  = LEN_W'(1);
  int                  matched_bytes  = 0;

  match_result_t       expected_results [$];
  match_result_t       oldest_result;

  // idling knobs, in percent of cycles
  int                  src_idle_pct   = 0;
  int                  sink_stall_pct = 0;
  int                  hold_left      = 0;
  int                  mismatches     = 0;
  int                  quiet_cycles   = 0;

  always #(CLK_PERIOD / 2) clk = ~clk;

  stream_string_wait_matcher_core DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  task automatic report_mismatch(input string what);
    if (mismatches < PRINT_CAP) $display("%0t: mismatch, %s", $realtime, what);
    mismatches++;
  endtask

  // length code as the block uses it: zero means one, saturates at the maximum
  function automatic int active_length();
    int n;
    n = length_shadow;
    if (n < 1) n = 1;
    if (n > MAX_PATTERN_BYTES) n = MAX_PATTERN_BYTES;
    return n;
  endfunction

  function automatic logic [7:0] pattern_byte(input int k);
    return pattern_shadow[8*k +: 8];
  endfunction

  // count the word into the match and return the result it should produce
  function automatic match_result_t advance_match(input cmd_t c, input logic [7:0] b);
    logic [7:0]    window [MAX_PATTERN_BYTES+1];
    int            len;
    int            cnt;
    int            k;
    int            i;
    bit            hit;
    match_result_t res;
    len = active_length();
    cnt = matched_bytes;
    // a count left over from a longer pattern is capped first
    if (cnt > len - 1) cnt = len - 1;
    res.status = STS_WAITING;
    if (c == CMD_TIMEOUT) begin
      res.status = STS_TIMEOUT;
      cnt = 0;
    end else if (pattern_byte(cnt) == b) begin
      cnt++;
      if (cnt == len) begin
        res.status = STS_FOUND;
        cnt = 0;
      end
    end else begin
      // window of recent bytes: matched prefix followed by the new byte
      for (i = 0; i < cnt; i++) window[i] = pattern_byte(i);
      window[cnt] = b;
      // keep the longest proper suffix that is still a pattern prefix
      k = cnt;
      hit = 1'b0;
      while (k > 0 && !hit) begin
        hit = 1'b1;
        for (i = 0; i < k; i++)
          if (window[cnt + 1 - k + i] != pattern_byte(i)) hit = 1'b0;
        if (!hit) k--;
      end
      cnt = k;
    end
    matched_bytes = cnt;
    res.progress = PROG_W'(cnt);
    return res;
  endfunction

  // offer one word, wait for it to be taken, then log what it should produce
  task automatic push_word(input cmd_t c, input logic [7:0] b, input bit typed,
                           input match_result_t typed_res);
    match_result_t predicted;
    // sender gap: valid drops for a random number of cycles
    while ($urandom_range(99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.cmd     <= c;
    in_ch.rx_byte <= b;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    predicted = advance_match(c, b);
    expected_results.push_back(typed ? typed_res : predicted);
  endtask

  // stop offering and let every pending result drain before touching registers
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // apb write, then read the register straight back
  task automatic write_reg(input reg_idx_t r, input logic [PAT_W-1:0] value);
    logic [DATA_W-1:0] readback_exp;
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= ADDR_W'({r, 3'b000});
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    // register takes the value at this edge
    if (r == REG_PATTERN) pattern_shadow = value;
    else length_shadow = value[LEN_W-1:0];
    readback_exp = (r == REG_PATTERN) ? pattern_shadow : DATA_W'(length_shadow);
    // read setup follows the write access directly, psel stays up
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    if (cfg_prdata !== readback_exp)
      report_mismatch($sformatf("register %s reads %h, expected %h", r.name(), cfg_prdata,
                                readback_exp));
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  // result side: check each taken word against the oldest expectation and
  // drive ready, with the long hold-off counted here
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) begin
        if (expected_results.size() == 0) begin
          report_mismatch("result word with nothing expected");
        end else begin
          oldest_result = expected_results.pop_front();
          if (out_ch.status !== oldest_result.status)
            report_mismatch($sformatf("status %0d, expected %0d", out_ch.status,
                                      oldest_result.status));
          if (out_ch.progress !== oldest_result.progress)
            report_mismatch($sformatf("progress %0d, expected %0d", out_ch.progress,
                                      oldest_result.progress));
        end
      end
      if (hold_left > 0) begin
        out_ch.ready <= 1'b0;
        hold_left--;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
      end
    end
  end

  // watchdog: any handshake on any port counts as progress
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_psel && cfg_penable))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL stream_string_wait_matcher_core");
      $finish;
    end
  end

  initial begin
    int           row;
    int           phase;
    int           item;
    int           pick;
    int           next_idx;
    int           phase_src;
    int           phase_sink;
    logic [7:0]   sym_a;
    logic [7:0]   sym_b;
    logic [7:0]   rx;
    logic [PAT_W-1:0] pat;
    logic [LEN_W-1:0] len_code;

    // every input known from time zero
    rst_n          <= 1'b0;
    in_ch.valid    <= 1'b0;
    in_ch.cmd      <= CMD_BYTE;
    in_ch.rx_byte  <= '0;
    cfg_psel       <= 1'b0;
    cfg_penable    <= 1'b0;
    cfg_pwrite     <= 1'b0;
    cfg_paddr      <= '0;
    cfg_pwdata     <= '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // directed script, no idling
    for (row = 0; row < NUM_ROWS; row++) begin
      if (DIRECTED[row].kind == ROW_REG) begin
        settle();
        write_reg(DIRECTED[row].regsel, DIRECTED[row].value);
      end else begin
        push_word(DIRECTED[row].cmd, DIRECTED[row].value[7:0], DIRECTED[row].typed,
                  DIRECTED[row].result);
      end
    end

    // random phases, each with its own register setting and idling mix
    for (phase = 0; phase < NUM_PHASES; phase++) begin
      settle();
      // two-symbol alphabet makes overlapping prefixes common
      sym_a = 8'($urandom_range(255));
      sym_b = sym_a ^ 8'($urandom_range(1, 255));
      for (int k = 0; k < MAX_PATTERN_BYTES; k++)
        pat[8*k +: 8] = $urandom_range(1) ? sym_a : sym_b;
      case (phase)
        0: len_code = LEN_W'(MAX_PATTERN_BYTES);
        1: begin
          pat = '0;
          len_code = LEN_W'(1);
        end
        2: begin
          pat = '1;
          len_code = '1;
        end
        3: begin
          pat = {32'($urandom), 32'($urandom)};
          len_code = '0;
        end
        4: len_code = LEN_W'($urandom_range(2, 7));
        default: len_code = LEN_W'($urandom_range(0, 15));
      endcase
      write_reg(REG_PATTERN, pat);
      write_reg(REG_LENGTH, PAT_W'(len_code));

      case (phase)
        1: begin
          phase_src = 85;
          phase_sink = 0;
        end
        2: begin
          phase_src = 0;
          phase_sink = 85;
        end
        3, 5: begin
          phase_src = 22;
          phase_sink = 22;
        end
        default: begin
          phase_src = 0;
          phase_sink = 0;
        end
      endcase

      for (item = 0; item < ITEMS_PER_PHASE; item++) begin
        // a stretch without idling in every phase
        src_idle_pct   = (item % 50 < 10) ? 0 : phase_src;
        sink_stall_pct = (item % 50 < 10) ? 0 : phase_sink;
        // long receiver hold-off while words keep coming, so the block backs up
        if (phase == 4 && item == 20) hold_left = HOLD_CYCLES;
        next_idx = matched_bytes;
        if (next_idx > active_length() - 1) next_idx = active_length() - 1;
        pick = $urandom_range(99);
        if (pick < 8) begin
          push_word(CMD_TIMEOUT, 8'($urandom_range(255)), 1'b0, '0);
        end else begin
          // mostly the byte that extends the match, then pattern bytes, then noise
          if (pick < 60) rx = pattern_byte(next_idx);
          else if (pick < 85) rx = pattern_byte($urandom_range(MAX_PATTERN_BYTES - 1));
          else rx = 8'($urandom_range(255));
          push_word(CMD_BYTE, rx, 1'b0, '0);
        end
      end
    end

    src_idle_pct   = 0;
    sink_stall_pct = 0;
    settle();
    if (mismatches == 0) begin
      $display("PASS stream_string_wait_matcher_core");
    end else begin
      $display("FAIL stream_string_wait_matcher_core");
    end
    $finish;
  end

endmodule

/* stream_string_wait_matcher_core.f */
rtl/core/sswm_pkg.sv
rtl/core/sswm_if.sv
rtl/core/sswm_ctrl.sv
rtl/core/sswm_dp.sv
rtl/core/stream_string_wait_matcher_core.sv
rtl/core/sswm_checker.sv
dv/stream_string_wait_matcher_core_tb.sv
